// File: rtl/ujb_pkg.sv
`timescale 1ns / 1ps

package ujb_pkg;

  localparam int RingDepth = 8192;
  localparam int ChunkLen  = 32;

  localparam int LevelWidth = 14;
  localparam int SampleWidth = 16;
  localparam int UnderrunWidth = 32;

  localparam logic [LevelWidth-1:0] PrebufferReset = 14'd1600;
  localparam logic [LevelWidth-1:0] MaxLevelReset  = 14'd4000;

  // mu-law field masks and bias
  localparam logic [7:0] MuMantMask = 8'h0F;
  localparam logic [7:0] MuBias     = 8'h84;
  localparam logic [7:0] MuExpMask  = 8'h70;
  localparam logic [7:0] MuSignMask = 8'h80;

  typedef enum logic [1:0] {
    FuncPush    = 2'd0,
    FuncPull    = 2'd1,
    FuncClear   = 2'd2,
    FuncRestart = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic CfgPrebuffer = 1'b0;
  localparam logic CfgMaxLevel  = 1'b1;

  typedef struct packed {
    func_e      func;
    logic [7:0] ulaw_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] mid_sample;
    logic signed [SampleWidth-1:0] cur_sample;
    logic                          last_of_chunk;
    logic                          audible;
    logic                          playing;
    logic [LevelWidth-1:0]         buffered_count;
    logic [UnderrunWidth-1:0]      underrun_total;
  } out_word_t;

  function automatic logic signed [SampleWidth-1:0] mulaw_decode(input logic [7:0] code);
    logic [7:0]             v;
    logic [7:0]             base;
    logic [2:0]             expo;
    logic [SampleWidth-1:0] mag;
    v    = ~code;
    // mantissa (low nibble) times eight plus bias, at most 8'hFC
    base = {v[3:0], 3'b000} + MuBias;
    expo = 3'((v & MuExpMask) >> 4);
    mag  = SampleWidth'(base) << expo;
    if ((v & MuSignMask) != 8'h00) begin
      mulaw_decode = SampleWidth'(MuBias) - mag;
    end else begin
      mulaw_decode = mag - SampleWidth'(MuBias);
    end
  endfunction

endpackage

// File: rtl/ujb_ram.sv
`timescale 1ns / 1ps

// simple dual port RAM, one write and one registered read
module ujb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ulaw_jitter_buffer_upsampler_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Word
// --------+-----+------------------------+---------------------------------
// in      | in  | in_valid_i / in_stall_o | func, ulaw_byte
// out     | out | out_valid_o/out_stall_i | mid, cur, flags, count, underruns
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i (14 bit)
//
// Push, clear and restart give no output. A pull is accepted in StIdle;
// unless still short of the prebuffer level, StTrim drops chunks one at a
// time while above max level, then decides; then each sample passes StRead
// and StData (ring read), or StSil if silent. Output stalls hold StRead/StSil.
// Items are held off until a pull ends. Reset (async, active low) clears
// pointers and counts and reloads the default levels; the ring is not cleared.
module ulaw_jitter_buffer_upsampler_top #(
  parameter int RING_DEPTH = ujb_pkg::RingDepth,
  parameter int CHUNK_LEN  = ujb_pkg::ChunkLen
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ujb_pkg::in_word_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ujb_pkg::out_word_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [ujb_pkg::LevelWidth-1:0]   cfg_wdata_i
);

  localparam int PW   = $clog2(RING_DEPTH);       // ring pointer
  localparam int FW   = $clog2(RING_DEPTH + 1);   // fill count
  localparam int CW   = $clog2(CHUNK_LEN + 1);    // chunk counter / cut
  localparam int LW   = ujb_pkg::LevelWidth;
  localparam int SW   = ujb_pkg::SampleWidth;
  localparam int UW   = ujb_pkg::UnderrunWidth;
  localparam int CMPW = (FW > LW) ? FW : LW;

  // one-hot sequencer
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StTrim = 5'b00010,   // drop chunks above max level
    StRead = 5'b00100,   // issue ring read
    StData = 5'b01000,   // read data back, emit word
    StSil  = 5'b10000    // emit silent words
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            buf_q, buf_d;
  logic [SW-1:0]   prev_q, prev_d;
  logic [UW-1:0]   under_q, under_d;
  logic [LW-1:0]   pre_q, max_q;
  logic            aud_q, aud_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  ujb_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic            in_acc;
  logic            out_free;
  logic            ram_we, ram_re;
  logic [SW-1:0]   ram_rdata;
  logic [SW-1:0]   push_sample;
  logic [CMPW-1:0] fill_ext;
  logic            last;
  logic [CW-1:0]   cut;
  logic [PW:0]     rd_sum;
  logic [PW:0]     rd_inc;
  logic [PW:0]     wr_inc;
  logic signed [SW:0] sum, sum_adj;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  // output register empty now or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fill_ext   = CMPW'(fill_q);
  assign last       = (cnt_q == CW'(CHUNK_LEN - 1));
  assign push_sample = ujb_pkg::mulaw_decode(in_data_i.ulaw_byte);

  assign cut    = (fill_q < FW'(CHUNK_LEN)) ? CW'(fill_q) : CW'(CHUNK_LEN);
  assign rd_sum = {1'b0, rd_ptr_q} + (PW+1)'(cut);
  assign rd_inc = {1'b0, rd_ptr_q} + (PW+1)'(1);
  assign wr_inc = {1'b0, wr_ptr_q} + (PW+1)'(1);

  // midpoint, truncated toward zero
  assign sum     = {prev_q[SW-1], prev_q} + {ram_rdata[SW-1], ram_rdata};
  assign sum_adj = sum + (SW+1)'(sum[SW]);

  assign ram_we = in_acc && (in_data_i.func == ujb_pkg::FuncPush);
  assign ram_re = (state_q == StRead) && out_free;

  ujb_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_sample),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    buf_d    = buf_q;
    prev_d   = prev_q;
    under_d  = under_q;
    aud_d    = aud_q;
    cnt_d    = cnt_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_data_i.func)
            ujb_pkg::FuncPush: begin
              // full ring: oldest sample goes
              if (fill_q == FW'(RING_DEPTH)) begin
                rd_ptr_d = (rd_inc == (PW+1)'(RING_DEPTH)) ? '0 : rd_inc[PW-1:0];
              end else begin
                fill_d = fill_q + FW'(1);
              end
              wr_ptr_d = (wr_inc == (PW+1)'(RING_DEPTH)) ? '0 : wr_inc[PW-1:0];
            end
            ujb_pkg::FuncPull: begin
              cnt_d = '0;
              if (!buf_q || fill_ext >= CMPW'(pre_q)) begin
                buf_d   = 1'b0;
                state_d = StTrim;
              end else begin
                aud_d   = 1'b0;
                prev_d  = '0;
                state_d = StSil;
              end
            end
            ujb_pkg::FuncClear: begin
              wr_ptr_d = '0;
              rd_ptr_d = '0;
              fill_d   = '0;
              under_d  = '0;
            end
            ujb_pkg::FuncRestart: begin
              buf_d  = 1'b1;
              prev_d = '0;
            end
            default: ;
          endcase
        end
      end

      StTrim: begin
        if (fill_ext > CMPW'(max_q)) begin
          rd_ptr_d = (rd_sum >= (PW+1)'(RING_DEPTH)) ?
                     PW'(rd_sum - (PW+1)'(RING_DEPTH)) : rd_sum[PW-1:0];
          fill_d   = fill_q - FW'(cut);
        end else if (fill_q >= FW'(CHUNK_LEN)) begin
          // count is final for the whole chunk
          fill_d  = fill_q - FW'(CHUNK_LEN);
          aud_d   = 1'b1;
          state_d = StRead;
        end else begin
          buf_d   = 1'b1;
          under_d = under_q + UW'(1);
          aud_d   = 1'b0;
          prev_d  = '0;
          state_d = StSil;
        end
      end

      StRead: begin
        if (out_free) begin
          rd_ptr_d = (rd_inc == (PW+1)'(RING_DEPTH)) ? '0 : rd_inc[PW-1:0];
          state_d  = StData;
        end
      end

      StData: begin
        // output register is known empty here
        out_valid_d          = 1'b1;
        out_d.mid_sample     = sum_adj[SW:1];
        out_d.cur_sample     = ram_rdata;
        out_d.last_of_chunk  = last;
        out_d.audible        = aud_q;
        out_d.playing        = !buf_q;
        out_d.buffered_count = fill_ext[LW-1:0];
        out_d.underrun_total = under_q;
        prev_d = ram_rdata;
        cnt_d  = cnt_q + CW'(1);
        state_d = last ? StIdle : StRead;
      end

      StSil: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.mid_sample     = '0;
          out_d.cur_sample     = '0;
          out_d.last_of_chunk  = last;
          out_d.audible        = aud_q;
          out_d.playing        = !buf_q;
          out_d.buffered_count = fill_ext[LW-1:0];
          out_d.underrun_total = under_q;
          cnt_d   = cnt_q + CW'(1);
          state_d = last ? StIdle : StSil;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      buf_q       <= 1'b1;
      prev_q      <= '0;
      under_q     <= '0;
      aud_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pre_q       <= ujb_pkg::PrebufferReset;
      max_q       <= ujb_pkg::MaxLevelReset;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      buf_q       <= buf_d;
      prev_q      <= prev_d;
      under_q     <= under_d;
      aud_q       <= aud_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ujb_pkg::CfgPrebuffer: pre_q <= cfg_wdata_i;
          ujb_pkg::CfgMaxLevel:  max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the mu-law jitter buffer / 2x upsampler.
// A shadow copy of the ring, pointers, levels and playout state predicts every
// output word of a pull. The checker compares each accepted output word with
// the oldest prediction.
module testbench;
  import ujb_pkg::*;

  localparam int QuietLimit   = 20000;  // cycles without any handshake
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 100;
  localparam int HoldOffLen   = 400;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_idx_i   = CfgPrebuffer;
  logic [LevelWidth-1:0] cfg_wdata_i = '0;

  // traffic shaping
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_off_left   = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // shadow state of the block
  logic signed [SampleWidth-1:0] shadow_ring [RingDepth];
  int unsigned                   shadow_wr        = 0;
  int unsigned                   shadow_rd        = 0;
  int unsigned                   shadow_fill      = 0;
  bit                            shadow_buffering = 1'b1;
  logic signed [SampleWidth-1:0] shadow_prev      = '0;
  logic [UnderrunWidth-1:0]      shadow_underruns = '0;
  int unsigned                   shadow_prebuf    = PrebufferReset;
  int unsigned                   shadow_max       = MaxLevelReset;

  // predicted upsampled words, oldest first
  out_word_t pending_samples [$];
  out_word_t want_word;

  ulaw_jitter_buffer_upsampler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // G.711 mu-law expansion: complement, rebuild biased magnitude, apply sign
  function automatic logic signed [SampleWidth-1:0] expand_ulaw(input logic [7:0] code);
    logic [7:0] inv;
    int         magnitude;
    inv       = ~code;
    magnitude = ((int'(inv[3:0]) * 8) + int'(MuBias)) << inv[6:4];
    if (inv[7]) begin
      return SampleWidth'(int'(MuBias) - magnitude);
    end
    return SampleWidth'(magnitude - int'(MuBias));
  endfunction

  // Advance the shadow state by one accepted word; a pull queues its chunk.
  function automatic void predict_playout(input in_word_t w);
    logic signed [SampleWidth-1:0] chunk [ChunkLen];
    bit                            audible;
    int unsigned                   cut;
    out_word_t                     r;
    audible = 1'b0;
    case (w.func)
      FuncPush: begin
        // full ring: oldest sample goes first
        if (shadow_fill >= RingDepth) begin
          shadow_rd   = (shadow_rd + 1) % RingDepth;
          shadow_fill = RingDepth - 1;
        end
        shadow_ring[shadow_wr] = expand_ulaw(w.ulaw_byte);
        shadow_wr   = (shadow_wr + 1) % RingDepth;
        shadow_fill = shadow_fill + 1;
      end
      FuncClear: begin
        shadow_wr        = 0;
        shadow_rd        = 0;
        shadow_fill      = 0;
        shadow_underruns = '0;
      end
      FuncRestart: begin
        shadow_buffering = 1'b1;
        shadow_prev      = '0;
      end
      FuncPull: begin
        if (shadow_buffering && shadow_fill >= shadow_prebuf) begin
          shadow_buffering = 1'b0;
        end
        if (!shadow_buffering) begin
          // trim whole chunks (or the remainder) while above max level
          while (shadow_fill > shadow_max) begin
            cut         = (shadow_fill < ChunkLen) ? shadow_fill : ChunkLen;
            shadow_rd   = (shadow_rd + cut) % RingDepth;
            shadow_fill = shadow_fill - cut;
          end
          if (shadow_fill >= ChunkLen) begin
            for (int i = 0; i < ChunkLen; i++) begin
              chunk[i] = shadow_ring[(shadow_rd + i) % RingDepth];
            end
            shadow_rd   = (shadow_rd + ChunkLen) % RingDepth;
            shadow_fill = shadow_fill - ChunkLen;
            audible     = 1'b1;
          end else begin
            shadow_buffering = 1'b1;
            shadow_underruns = shadow_underruns + 1'b1;
          end
        end
        for (int i = 0; i < ChunkLen; i++) begin
          if (audible) begin
            // midpoint truncates toward zero
            r.mid_sample = SampleWidth'((int'(shadow_prev) + int'(chunk[i])) / 2);
            r.cur_sample = chunk[i];
            shadow_prev  = chunk[i];
          end else begin
            r.mid_sample = '0;
            r.cur_sample = '0;
          end
          r.last_of_chunk  = (i == ChunkLen - 1);
          r.audible        = audible;
          r.playing        = !shadow_buffering;
          r.buffered_count = LevelWidth'(shadow_fill);
          r.underrun_total = shadow_underruns;
          pending_samples.push_back(r);
        end
        if (!audible) begin
          shadow_prev = '0;
        end
      end
    endcase
  endfunction

  // Receiver: random stall, or a forced hold-off run.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Output word checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected output word: mid %0d cur %0d last %b count %0d",
                   out_data_o.mid_sample, out_data_o.cur_sample,
                   out_data_o.last_of_chunk, out_data_o.buffered_count);
        end
      end else begin
        want_word = pending_samples.pop_front();
        if (out_data_o.mid_sample !== want_word.mid_sample ||
            out_data_o.cur_sample !== want_word.cur_sample ||
            out_data_o.last_of_chunk !== want_word.last_of_chunk ||
            out_data_o.audible !== want_word.audible ||
            out_data_o.playing !== want_word.playing ||
            out_data_o.buffered_count !== want_word.buffered_count ||
            out_data_o.underrun_total !== want_word.underrun_total) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: expected mid %0d cur %0d last %b aud %b play %b",
                     $realtime, want_word.mid_sample, want_word.cur_sample,
                     want_word.last_of_chunk, want_word.audible, want_word.playing);
            $display("  expected count %0d underruns %0d",
                     want_word.buffered_count, want_word.underrun_total);
            $display("  got mid %0d cur %0d last %b aud %b play %b count %0d underruns %0d",
                     out_data_o.mid_sample, out_data_o.cur_sample,
                     out_data_o.last_of_chunk, out_data_o.audible, out_data_o.playing,
                     out_data_o.buffered_count, out_data_o.underrun_total);
          end
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Offer one input word; returns at the edge that accepts it.
  task automatic offer_word(input func_e f, input logic [7:0] code);
    in_word_t w;
    w.func      = f;
    w.ulaw_byte = code;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_playout(w);
  endtask

  // Stop sending until every predicted word is out and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_levels(input int unsigned pre, input int unsigned top);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgPrebuffer;
    cfg_wdata_i <= LevelWidth'(pre);
    @(posedge clk_i);
    cfg_idx_i   <= CfgMaxLevel;
    cfg_wdata_i <= LevelWidth'(top);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    shadow_prebuf = LevelWidth'(pre);
    shadow_max    = LevelWidth'(top);
  endtask

  // Pull right after reset: still buffering, silent chunk, no underrun.
  task automatic test_idle_pull();
    offer_word(FuncPull, 8'h00);
  endtask

  // Decode corners, then a short pull that underruns.
  task automatic test_decode_extremes();
    logic [7:0] codes [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE, 8'h0F, 8'hF0};
    settle();
    set_levels(0, RingDepth);
    foreach (codes[i]) begin
      offer_word(FuncPush, codes[i]);
    end
    offer_word(FuncPull, 8'hA5);
  endtask

  // Fewer than a chunk stored but above max level: trim empties the ring.
  task automatic test_trim_near_empty();
    settle();
    set_levels(0, 0);
    offer_word(FuncRestart, 8'h5A);
    offer_word(FuncPull, 8'h00);
  endtask

  // Clear empties the ring and the underrun count, state kept.
  task automatic test_clear();
    repeat (3) offer_word(FuncPush, 8'($urandom_range(255)));
    offer_word(FuncClear, 8'hFF);
    offer_word(FuncPull, 8'h00);
  endtask

  // Levels at the ring depth: never leaves buffering, never trims.
  task automatic test_large_levels();
    settle();
    set_levels(RingDepth, RingDepth);
    repeat (4) offer_word(FuncPush, 8'($urandom_range(255)));
    offer_word(FuncPull, 8'h00);
  endtask

  // Long receiver hold-off while pulls and pushes keep coming.
  task automatic test_backpressure();
    settle();
    set_levels(0, RingDepth);
    hold_off_left = HoldOffLen;
    repeat (40) offer_word(FuncPush, 8'($urandom_range(255)));
    offer_word(FuncPull, 8'($urandom_range(255)));
    repeat (40) offer_word(FuncPush, 8'($urandom_range(255)));
    offer_word(FuncPull, 8'($urandom_range(255)));
    repeat (8) offer_word(FuncPush, 8'($urandom_range(255)));
    settle();
  endtask

  // Push bursts followed by pulls, with restarts, clears and level changes.
  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          rounds;
    int          burst;
    int          roll;
    int unsigned pre;
    int unsigned top;
    sent   = 0;
    rounds = 0;
    while (sent < n_items) begin
      if (rounds % 2 == 0) begin
        case ($urandom_range(7))
          0:       pre = 0;
          1:       pre = RingDepth;
          default: pre = $urandom_range(96);
        endcase
        case ($urandom_range(7))
          0:       top = 0;
          1:       top = RingDepth;
          default: top = $urandom_range(200, 16);
        endcase
        settle();
        set_levels(pre, top);
      end
      roll = $urandom_range(99);
      if (roll < 70 || roll >= 94) begin
        burst = $urandom_range(32, 1);
        repeat (burst) offer_word(FuncPush, 8'($urandom_range(255)));
        sent += burst;
      end
      if (roll < 82) begin
        offer_word(FuncPull, 8'($urandom_range(255)));
        sent++;
      end else if (roll < 90) begin
        offer_word(FuncRestart, 8'($urandom_range(255)));
        sent++;
      end else if (roll < 94) begin
        offer_word(FuncClear, 8'($urandom_range(255)));
        sent++;
      end
      rounds++;
    end
  endtask

  // Two whole chunks above max level are trimmed before a full chunk plays.
  task automatic test_deep_trim();
    settle();
    set_levels(0, 40);
    offer_word(FuncClear, 8'h00);
    repeat (96) offer_word(FuncPush, 8'($urandom_range(255)));
    offer_word(FuncPull, 8'h00);
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // slow sender, heavily stalled receiver
    sender_idle_pct = 37;
    stall_pct       = 81;
    test_idle_pull();
    test_decode_extremes();
    test_trim_near_empty();
    test_clear();
    test_large_levels();
    test_backpressure();
    test_random_traffic(36);

    // roles swapped
    sender_idle_pct = 81;
    stall_pct       = 37;
    test_random_traffic(36);

    // full rate both sides
    sender_idle_pct = 0;
    stall_pct       = 0;
    test_random_traffic(36);
    test_deep_trim();

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ujb_pkg.sv
rtl/ujb_ram.sv
rtl/ulaw_jitter_buffer_upsampler_top.sv
tb/testbench.sv
